// File: src/buzzer_pattern_sequencer_assert.svh
// ----------------------------------------------------------------------------
// buzzer pattern sequencer assertion macros
// implication checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BUZZER_PATTERN_SEQUENCER_ASSERT_SVH
`define BUZZER_PATTERN_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define BPS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bps assertion failed");
// next-cycle implication
`define BPS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bps assertion failed");
`else
`define BPS_ASSERT_IMP(name, clk, rst, ante, cons)
`define BPS_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

// File: src/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// types, codes and microprogram of the buzzer pattern sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

   localparam int DATA_W = 8;
   localparam int UPC_W  = 4;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_ON    = 2'd2,
      PH_OFF   = 2'd3
   } phase_type;

   // datapath action of one microinstruction
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_DEC,
      ACT_TAKE,
      ACT_RESTART,
      ACT_END,
      ACT_START,
      ACT_STOP,
      ACT_WRITE,
      ACT_RESP
   } act_type;

   // jump condition; false falls through to the next step
   typedef enum logic [3:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_ACCEPT,
      C_DISPATCH,
      C_PH_IDLE,
      C_PH_START,
      C_TICKS_NZ,
      C_POS_END,
      C_IS_STOP,
      C_IS_ZERO,
      C_NO_RPT
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      upc_type  target;
   } ucode_type;

   typedef struct packed {
      logic ph_idle;
      logic ph_start;
      logic ticks_nz;
      logic pos_end;
      logic is_stop;
      logic is_zero;
      logic no_rpt;
   } status_type;

   localparam upc_type UA_IDLE     = 4'd0;
   localparam upc_type UA_DISPATCH = 4'd1;
   localparam upc_type UA_TICK     = 4'd2;
   localparam upc_type UA_TICK_ST  = 4'd3;
   localparam upc_type UA_COUNT    = 4'd4;
   localparam upc_type UA_EXPIRE   = 4'd5;
   localparam upc_type UA_LOAD     = 4'd6;
   localparam upc_type UA_EXAM     = 4'd7;
   localparam upc_type UA_TAKE     = 4'd8;
   localparam upc_type UA_RESP     = 4'd9;
   localparam upc_type UA_STOPENT  = 4'd10;
   localparam upc_type UA_RESTART  = 4'd11;
   localparam upc_type UA_END      = 4'd12;
   localparam upc_type UA_START    = 4'd13;
   localparam upc_type UA_STOP     = 4'd14;
   localparam upc_type UA_WRITE    = 4'd15;

   function automatic ucode_type ucode_rom(input upc_type addr);
      ucode_type w;
      unique case (addr)
         UA_IDLE:     w = '{ACT_NONE,    C_NO_ACCEPT, UA_IDLE};
         UA_DISPATCH: w = '{ACT_NONE,    C_DISPATCH,  UA_IDLE};
         UA_TICK:     w = '{ACT_NONE,    C_PH_IDLE,   UA_RESP};
         UA_TICK_ST:  w = '{ACT_NONE,    C_PH_START,  UA_LOAD};
         UA_COUNT:    w = '{ACT_DEC,     C_NEXT,      UA_IDLE};
         UA_EXPIRE:   w = '{ACT_NONE,    C_TICKS_NZ,  UA_RESP};
         UA_LOAD:     w = '{ACT_NONE,    C_POS_END,   UA_END};
         UA_EXAM:     w = '{ACT_NONE,    C_IS_STOP,   UA_STOPENT};
         UA_TAKE:     w = '{ACT_TAKE,    C_IS_ZERO,   UA_LOAD};
         UA_RESP:     w = '{ACT_RESP,    C_ALWAYS,    UA_IDLE};
         UA_STOPENT:  w = '{ACT_NONE,    C_NO_RPT,    UA_END};
         UA_RESTART:  w = '{ACT_RESTART, C_ALWAYS,    UA_LOAD};
         UA_END:      w = '{ACT_END,     C_ALWAYS,    UA_RESP};
         UA_START:    w = '{ACT_START,   C_ALWAYS,    UA_RESP};
         UA_STOP:     w = '{ACT_STOP,    C_ALWAYS,    UA_RESP};
         UA_WRITE:    w = '{ACT_WRITE,   C_ALWAYS,    UA_RESP};
         default:     w = '{ACT_NONE,    C_ALWAYS,    UA_IDLE};
      endcase
      return w;
   endfunction

   function automatic upc_type dispatch_target(input cmd_type cmd);
      upc_type t;
      unique case (cmd)
         CMD_TICK:  t = UA_TICK;
         CMD_START: t = UA_START;
         CMD_STOP:  t = UA_STOP;
         CMD_WRITE: t = UA_WRITE;
         default:   t = UA_IDLE;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// File: src/bps_ram.sv
// ----------------------------------------------------------------------------
// bps_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/bps_useq.sv
// ----------------------------------------------------------------------------
// bps_useq
// microprogram counter, control store and jump logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bps_useq import bps_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire cmd_type    cmd,
   input  wire status_type status,
   output ucode_type       ctrl,
   output logic            idle
);

   upc_type upc_ff;
   upc_type upc_in;
   logic    jump;

   always_comb begin
      ctrl = ucode_rom(upc_ff);
      unique case (ctrl.cond)
         C_NEXT:      jump = 1'b0;
         C_ALWAYS:    jump = 1'b1;
         C_NO_ACCEPT: jump = !accept;
         C_DISPATCH:  jump = 1'b1;
         C_PH_IDLE:   jump = status.ph_idle;
         C_PH_START:  jump = status.ph_start;
         C_TICKS_NZ:  jump = status.ticks_nz;
         C_POS_END:   jump = status.pos_end;
         C_IS_STOP:   jump = status.is_stop;
         C_IS_ZERO:   jump = status.is_zero;
         C_NO_RPT:    jump = status.no_rpt;
         default:     jump = 1'b0;
      endcase
      if (!jump) begin
         upc_in = upc_type'(upc_ff + 1'b1);
      end else if (ctrl.cond == C_DISPATCH) begin
         upc_in = dispatch_target(cmd);
      end else begin
         upc_in = ctrl.target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign idle = (upc_ff == UA_IDLE);

endmodule

`default_nettype wire

// File: src/buzzer_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// plays an on/off buzzer pattern from a byte sequence memory, one command
// per transfer, one result per command
// ----------------------------------------------------------------------------
// throughput: one command at a time, the next transfer the cycle after the strobe
// reset: busy stays high while the memory is cleared
// the result is shown for one cycle and the receiver cannot stall it
`timescale 1ns / 1ps
`default_nettype none
`include "buzzer_pattern_sequencer_assert.svh"

module buzzer_pattern_sequencer import bps_pkg::*; #(
   parameter int SEQ_DEPTH = 64,
   parameter int STOP_MARK = 240
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_command,
   input  wire logic [5:0] req_entry_address,
   input  wire logic [7:0] req_entry_value,
   output logic            rsp_strobe,
   output logic            rsp_buzzer_on,
   output logic            rsp_level_changed,
   output logic            rsp_finished,
   output logic [1:0]      rsp_mode
);

   localparam int ADDR_W = $clog2(SEQ_DEPTH);
   // position must be able to hold SEQ_DEPTH itself (end of memory)
   localparam int POS_W = $clog2(SEQ_DEPTH + 1);
   localparam logic [DATA_W-1:0] STOP_VAL  = DATA_W'(STOP_MARK);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SEQ_DEPTH - 1);
   localparam logic [POS_W-1:0]  END_POS   = POS_W'(SEQ_DEPTH);

   // sequencer handshake
   logic       accept;
   logic       seq_idle;
   ucode_type  ctrl;
   status_type status;

   // captured command
   cmd_type           cmd_ff, cmd_in;
   logic [5:0]        addr_ff, addr_in;
   logic [DATA_W-1:0] val_ff, val_in;

   // playback state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] rep_ff, rep_in;
   logic [DATA_W-1:0] ticks_ff, ticks_in;
   phase_type         phase_ff, phase_in;
   logic              level_ff, level_in;
   logic              chg_ff, chg_in;
   logic              fin_ff, fin_in;
   logic              restarted_ff, restarted_in;

   // post-reset clearing sweep
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   // sequence memory port
   logic              ram_we;
   logic [ADDR_W-1:0] ram_wa;
   logic [DATA_W-1:0] ram_wd;
   logic [DATA_W-1:0] rd_data;
   logic [DATA_W-1:0] rep_limit;

   assign busy   = clearing_ff | !seq_idle;
   assign accept = start & !busy;

   // ---------------------------------------------------------------------
   // microcoded control
   // ---------------------------------------------------------------------
   // rd_data always holds the entry at the position of the previous cycle;
   // the program spends one step on the read before it looks at the data
   assign rep_limit = rd_data - STOP_VAL;

   always_comb begin
      status.ph_idle  = (phase_ff == PH_IDLE);
      status.ph_start = (phase_ff == PH_START);
      status.ticks_nz = (ticks_ff != '0);
      status.pos_end  = (pos_ff >= END_POS);
      status.is_stop  = (rd_data >= STOP_VAL);
      status.is_zero  = (rd_data == '0);
      // only one restart per command; a second one means nothing to play
      status.no_rpt   = restarted_ff || !(rep_ff < rep_limit);
   end

   bps_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cmd    (cmd_ff),
      .status (status),
      .ctrl   (ctrl),
      .idle   (seq_idle)
   );

   // ---------------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------------
   always_comb begin
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      rep_in       = rep_ff;
      ticks_in     = ticks_ff;
      phase_in     = phase_ff;
      level_in     = level_ff;
      chg_in       = chg_ff;
      fin_in       = fin_ff;
      restarted_in = restarted_ff;

      // new transfer: latch the command and clear the per-command events
      if (accept) begin
         cmd_in       = cmd_type'(req_command);
         addr_in      = req_entry_address;
         val_in       = req_entry_value;
         chg_in       = 1'b0;
         fin_in       = 1'b0;
         restarted_in = 1'b0;
      end

      unique case (ctrl.act)
         ACT_DEC: begin
            if (ticks_ff != '0) begin
               ticks_in = ticks_ff - 1'b1;
            end
         end
         ACT_TAKE: begin
            // even positions are on durations, odd ones off durations
            pos_in = pos_ff + 1'b1;
            if (rd_data != '0) begin
               level_in = ~pos_ff[0];
               chg_in   = chg_ff | (level_ff == pos_ff[0]);
               ticks_in = rd_data;
               phase_in = pos_ff[0] ? PH_OFF : PH_ON;
            end
         end
         ACT_RESTART: begin
            rep_in       = rep_ff + 1'b1;
            pos_in       = '0;
            restarted_in = 1'b1;
         end
         ACT_END: begin
            level_in = 1'b0;
            chg_in   = chg_ff | level_ff;
            phase_in = PH_IDLE;
            fin_in   = 1'b1;
         end
         ACT_START: begin
            pos_in   = '0;
            rep_in   = '0;
            ticks_in = '0;
            phase_in = PH_START;
         end
         ACT_STOP: begin
            level_in = 1'b0;
            chg_in   = chg_ff | level_ff;
            phase_in = PH_IDLE;
         end
         ACT_NONE, ACT_WRITE, ACT_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // clearing sweep owns the write port right after reset
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         ram_we = 1'b1;
         ram_wa = clr_cnt_ff;
         ram_wd = '0;
      end else begin
         // writes beyond the memory are dropped
         ram_we = (ctrl.act == ACT_WRITE) && (int'(addr_ff) < SEQ_DEPTH);
         ram_wa = ADDR_W'(addr_ff);
         ram_wd = val_ff;
      end
   end

   bps_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SEQ_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (pos_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rep_ff       <= '0;
         ticks_ff     <= '0;
         phase_ff     <= PH_IDLE;
         level_ff     <= 1'b0;
         chg_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         restarted_ff <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
      end else begin
         pos_ff       <= pos_in;
         rep_ff       <= rep_in;
         ticks_ff     <= ticks_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         chg_ff       <= chg_in;
         fin_ff       <= fin_in;
         restarted_ff <= restarted_in;
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
   end

   // command payload needs no reset
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      val_ff  <= val_in;
   end

   // ---------------------------------------------------------------------
   // result
   // ---------------------------------------------------------------------
   assign rsp_strobe        = (ctrl.act == ACT_RESP);
   assign rsp_buzzer_on     = level_ff;
   assign rsp_level_changed = chg_ff;
   assign rsp_finished      = fin_ff;
   assign rsp_mode          = phase_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `BPS_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `BPS_ASSERT_NXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   `BPS_ASSERT_IMP(a_finish_idle, clock, reset, fin_ff, phase_ff == PH_IDLE && !level_ff)
   `BPS_ASSERT_IMP(a_clear_quiet, clock, reset, clearing_ff, busy && !rsp_strobe)
   `BPS_ASSERT_IMP(a_phase_level, clock, reset, phase_ff == PH_ON || phase_ff == PH_OFF, level_ff == (phase_ff == PH_ON))

endmodule

`default_nettype wire
